### rtl/core/box_blur_3x3_nonzero_mean_defines.svh
// Assertion macros shared by the box blur RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef BOX_BLUR_3X3_NONZERO_MEAN_DEFINES_SVH
`define BOX_BLUR_3X3_NONZERO_MEAN_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BBNZ_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BBNZ_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

### rtl/core/bbnz_pkg.sv
// Types, register indexes and the reciprocal table of the 3x3 nonzero-mean blur.
// No dependencies; the lane, merge and top-level files refer to it by scoped names.
package bbnz_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  // Quotients come from sum * ceil(2^16 / count) >> 16, exact for sums below 2296.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 17;
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;

  typedef logic [23:0] rgb_t;
  typedef rgb_t [8:0] win_t;
  typedef logic [8:0][7:0] chan_win_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       pad_item;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_pixel;
  } pix_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_DIV
  } state_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd5:    m = 17'd13108;
      4'd6:    m = 17'd10923;
      4'd7:    m = 17'd9363;
      4'd8:    m = 17'd8192;
      4'd9:    m = 17'd7282;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

### rtl/core/bbnz_line_store.sv
// One line store: single write port, single read port with registered read data.
// Depends on nothing; instantiated twice by box_blur_3x3_nonzero_mean.
module bbnz_line_store #(
  parameter int DEPTH = 1024,
  parameter int DW    = 24
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/bbnz_lane.sv
// One channel lane: sums the nine window bytes, counts the nonzero ones, then divides.
// Depends on bbnz_pkg for the reciprocal table and widths.
module bbnz_lane (
  input  logic                clk,
  input  logic                load,
  input  bbnz_pkg::chan_win_t vals,
  output logic [7:0]          quot
);

  logic [bbnz_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [bbnz_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [bbnz_pkg::SUM_W+bbnz_pkg::RECIP_W-1:0] prod;

  always_comb begin
    sum_nxt = '0;
    cnt_nxt = '0;
    for (int k = 0; k < 9; k++) begin
      sum_nxt = sum_nxt + bbnz_pkg::SUM_W'(vals[k]);
      cnt_nxt = cnt_nxt + bbnz_pkg::CNT_W'(vals[k] != 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // A count of zero maps to a reciprocal of zero, so an all-zero window gives 0.
  assign prod = (bbnz_pkg::SUM_W+bbnz_pkg::RECIP_W)'(sum_r) *
                (bbnz_pkg::SUM_W+bbnz_pkg::RECIP_W)'(bbnz_pkg::recip(cnt_r));
  assign quot = prod[bbnz_pkg::RECIP_SHIFT +: 8];

endmodule

### rtl/core/bbnz_merge.sv
// Merge stage: gathers the three lane quotients into one result beat and holds it.
// Depends on bbnz_pkg for the result struct.
module bbnz_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic [7:0]         red_q,
  input  logic [7:0]         green_q,
  input  logic [7:0]         blue_q,
  input  logic               last,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output bbnz_pkg::pix_out_t out_data
);

  logic               out_valid_r, out_valid_nxt;
  bbnz_pkg::pix_out_t out_data_r;

  assign free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.red_out    <= red_q;
      out_data_r.green_out  <= green_q;
      out_data_r.blue_out   <= blue_q;
      out_data_r.last_pixel <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/box_blur_3x3_nonzero_mean.sv
// 3x3 nonzero-mean box blur over a raster RGB stream, with a pad row after each frame.
// A result beat goes from READ through the lane sum registers and DIV to the merge register.
// The single-issue sequencer (registered line-store read, lane sum stage, reciprocal multiply)
// takes no new input beat until the last beat's results have left DIV, which holds on stall.
// Reset (synchronous, rst_n low): counters and window clear, width 640, height 480; the line
// stores are not swept, a fill count clears at once and makes unwritten columns read as zero.
`include "box_blur_3x3_nonzero_mean_defines.svh"

module box_blur_3x3_nonzero_mean #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bbnz_pkg::pix_in_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bbnz_pkg::pix_out_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bbnz_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bbnz_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // CW indexes a column; WCW holds a width or fill count up to MAX_WIDTH itself.
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WCW  = $clog2(MAX_WIDTH + 1);
  localparam int HW   = bbnz_pkg::CFG_DATA_W;
  localparam int CMPW = (WCW > HW) ? WCW : HW;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  logic [HW-1:0] width_r, height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bbnz_pkg::FRAME_WIDTH_RST;
      height_r <= bbnz_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bbnz_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_data;
        bbnz_pkg::REG_FRAME_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Position of the incoming beat. A width of zero acts as one and a width above
  // MAX_WIDTH is clipped; a height of zero acts as one. Counters left out of range
  // by a configuration change restart at zero. Row height_eff is the pad row.
  // ---------------------------------------------------------------------------
  bbnz_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]  col_r, cur_c_r;
  logic [HW-1:0]  row_r, cur_r_r;
  logic           lastcol_r, padrow_r;
  bbnz_pkg::rgb_t pix_r;
  logic [WCW-1:0] fill_r;

  logic [WCW-1:0] w_eff;
  logic [HW-1:0]  h_eff;
  logic [CW-1:0]  c_eff;
  logic [HW-1:0]  r_eff;
  logic           lastcol, padrow, in_acc;
  bbnz_pkg::rgb_t pix_in;

  assign in_ready = (state_r == bbnz_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WCW'(1);
    end else if (CMPW'(width_r) > CMPW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(width_r);
    end
    h_eff   = (height_r == '0) ? HW'(1) : height_r;
    c_eff   = (WCW'(col_r) >= w_eff) ? '0 : col_r;
    r_eff   = (row_r > h_eff) ? '0 : row_r;
    lastcol = (WCW'(c_eff) == (w_eff - WCW'(1)));
    padrow  = (r_eff == h_eff);
    // Pad beats, and every beat of the pad row, enter the window as black.
    if (in_data.pad_item || padrow) begin
      pix_in = '0;
    end else begin
      pix_in = {in_data.red_in, in_data.green_in, in_data.blue_in};
    end
  end

  // The stream counters advance at accept time; the current position is kept
  // beside them for the rest of the beat's processing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= lastcol ? '0 : c_eff + CW'(1);
      if (lastcol) begin
        row_r <= padrow ? '0 : r_eff + HW'(1);
      end else begin
        row_r <= r_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_c_r   <= c_eff;
      cur_r_r   <= r_eff;
      lastcol_r <= lastcol;
      padrow_r  <= padrow;
      pix_r     <= pix_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores. Both are read at the beat's column on accept and written in the
  // following cycle, in READ. Columns are always written from zero upward without gaps, so
  // the written part of both stores is the prefix below fill_r; anything at or
  // beyond it is masked by in_fill and reads as zero.
  // ---------------------------------------------------------------------------
  bbnz_pkg::rgb_t above_rd, two_rd, above_mem, top_col, mid_col;
  logic           in_fill, mem_wr;

  assign mem_wr  = (state_r == bbnz_pkg::ST_READ);
  assign in_fill = (WCW'(cur_c_r) < fill_r);

  bbnz_line_store #(
    .DEPTH (MAX_WIDTH),
    .DW    (24)
  ) u_line_above (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (c_eff),
    .rd_data (above_rd),
    .wr_en   (mem_wr),
    .wr_addr (cur_c_r),
    .wr_data (pix_r)
  );

  bbnz_line_store #(
    .DEPTH (MAX_WIDTH),
    .DW    (24)
  ) u_line_two_above (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (c_eff),
    .rd_data (two_rd),
    .wr_en   (mem_wr),
    .wr_addr (cur_c_r),
    .wr_data (above_mem)
  );

  // The row above moves down into the row two above, unmasked by row number.
  assign above_mem = in_fill ? above_rd : '0;
  assign mid_col   = (cur_r_r != '0) ? above_mem : '0;
  assign top_col   = (cur_r_r > HW'(1) && in_fill) ? two_rd : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (mem_wr && !in_fill) begin
      fill_r <= WCW'(cur_c_r) + WCW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Window and sequencer. A beat passes through IDLE (accept) and READ
  // (window shift and line-store write), then one SUM/DIV pair per result. The
  // result for the pixel left of the new one is due whenever the beat is past
  // column zero of a row below the first. On the last column the window is
  // shifted once more with a black column to finish the row's final pixel; that
  // result is the frame's last when it comes from the pad row.
  // ---------------------------------------------------------------------------
  bbnz_pkg::win_t win_r, win_nxt, win_base, win_one, win_two;
  logic           pend2_r, pend2_nxt;
  logic           last_r, last_nxt;
  logic           emit1, emit2;
  logic           lane_ld, merge_ld, merge_free;

  function automatic bbnz_pkg::win_t win_shift(input bbnz_pkg::win_t w,
                                               input bbnz_pkg::rgb_t t,
                                               input bbnz_pkg::rgb_t m,
                                               input bbnz_pkg::rgb_t b);
    bbnz_pkg::win_t res;
    res[0] = w[1];
    res[1] = w[2];
    res[2] = t;
    res[3] = w[4];
    res[4] = w[5];
    res[5] = m;
    res[6] = w[7];
    res[7] = w[8];
    res[8] = b;
    return res;
  endfunction

  assign emit1    = (cur_r_r != '0) && (cur_c_r != '0);
  assign emit2    = lastcol_r && (cur_r_r != '0);
  assign win_base = (cur_c_r == '0) ? '0 : win_r;
  assign win_one  = win_shift(win_base, top_col, mid_col, pix_r);
  assign win_two  = win_shift(win_one, '0, '0, '0);

  always_comb begin
    state_nxt = state_r;
    win_nxt   = win_r;
    pend2_nxt = pend2_r;
    last_nxt  = last_r;
    lane_ld   = 1'b0;
    merge_ld  = 1'b0;
    case (state_r)
      bbnz_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = bbnz_pkg::ST_READ;
        end
      end
      bbnz_pkg::ST_READ: begin
        if (emit1) begin
          win_nxt   = win_one;
          pend2_nxt = emit2;
          last_nxt  = 1'b0;
          state_nxt = bbnz_pkg::ST_SUM;
        end else if (emit2) begin
          // First column of a one-pixel-wide row: only the closing result.
          win_nxt   = win_two;
          pend2_nxt = 1'b0;
          last_nxt  = padrow_r;
          state_nxt = bbnz_pkg::ST_SUM;
        end else begin
          win_nxt   = win_one;
          state_nxt = bbnz_pkg::ST_IDLE;
        end
      end
      bbnz_pkg::ST_SUM: begin
        lane_ld   = 1'b1;
        state_nxt = bbnz_pkg::ST_DIV;
      end
      bbnz_pkg::ST_DIV: begin
        if (merge_free) begin
          merge_ld = 1'b1;
          if (pend2_r) begin
            win_nxt   = win_shift(win_r, '0, '0, '0);
            pend2_nxt = 1'b0;
            last_nxt  = padrow_r;
            state_nxt = bbnz_pkg::ST_SUM;
          end else begin
            state_nxt = bbnz_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = bbnz_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bbnz_pkg::ST_IDLE;
      win_r   <= '0;
      pend2_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
      pend2_r <= pend2_nxt;
      last_r  <= last_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Three lanes, one per color channel, each summing and dividing its own bytes.
  // Lane 0 is red (bits 23:16), lane 1 green, lane 2 blue.
  // ---------------------------------------------------------------------------
  logic [2:0][7:0] quot;

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    bbnz_pkg::chan_win_t vals;

    always_comb begin
      for (int k = 0; k < 9; k++) begin
        vals[k] = win_r[k][23 - 8*ch -: 8];
      end
    end

    bbnz_lane u_lane (
      .clk  (clk),
      .load (lane_ld),
      .vals (vals),
      .quot (quot[ch])
    );
  end

  bbnz_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (merge_ld),
    .red_q     (quot[0]),
    .green_q   (quot[1]),
    .blue_q    (quot[2]),
    .last      (last_r),
    .free      (merge_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `BBNZ_ASSERT_NEXT(a_accept_to_read, in_acc, state_r == bbnz_pkg::ST_READ, "accept did not lead to READ")
  `BBNZ_ASSERT_NEXT(a_div_holds_on_stall, (state_r == bbnz_pkg::ST_DIV) && out_valid && !out_ready, state_r == bbnz_pkg::ST_DIV, "result dropped while output stalled")
  `BBNZ_ASSERT_NOW(a_pend_only_busy, pend2_r, (state_r == bbnz_pkg::ST_SUM) || (state_r == bbnz_pkg::ST_DIV), "second result pending outside SUM/DIV")
  `BBNZ_ASSERT_NOW(a_col_within_fill, state_r == bbnz_pkg::ST_SUM, WCW'(cur_c_r) < fill_r, "column beyond fill count after write")
  `BBNZ_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= WCW'(MAX_WIDTH), "fill count exceeds line store depth")

endmodule
